[sv/generational_graph_slot_allocator_core_macros.svh]
// Assertion helpers used by the allocator core
`ifndef GENERATIONAL_GRAPH_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define GENERATIONAL_GRAPH_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Condition holds at every edge outside reset
`define GGSA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define GGSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ggsa_pkg.sv]
package ggsa_pkg;

  localparam int GEN_W   = 32;
  localparam int ORDER_W = 48;

  // Request function codes
  localparam logic [2:0] F_ADD_NODE  = 3'd0;
  localparam logic [2:0] F_RM_NODE   = 3'd1;
  localparam logic [2:0] F_CHK_NODE  = 3'd2;
  localparam logic [2:0] F_ADD_EDGE  = 3'd3;
  localparam logic [2:0] F_RM_EDGE   = 3'd4;
  localparam logic [2:0] F_CHK_EDGE  = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_STALE    = 3'd2;
  localparam logic [2:0] ST_ENDPOINT = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [2:0]       func;
    logic [9:0]       handle_index;
    logic [GEN_W-1:0] handle_generation;
    logic [7:0]       source_index;
    logic [GEN_W-1:0] source_generation;
    logic [7:0]       target_index;
    logic [GEN_W-1:0] target_generation;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [9:0]       granted_index;
    logic [GEN_W-1:0] granted_generation;
  } rsp_t;

  // Control from the sequencer to the min-order tracker
  typedef struct packed {
    logic clear;
    logic sample;
  } trk_ctl_t;

  // Next generation, skipping zero on wrap
  function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

endpackage

[sv/ggsa_min_track.sv]
module ggsa_min_track #(
  parameter int EW = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ggsa_pkg::trk_ctl_t         ctl,
  input  logic                       match,
  input  logic [EW-1:0]              idx,
  input  logic [ggsa_pkg::ORDER_W-1:0] order,
  input  logic [ggsa_pkg::GEN_W-1:0] gen,
  output logic                       found,
  output logic [EW-1:0]              best_idx,
  output logic [ggsa_pkg::GEN_W-1:0] best_gen
);
  import ggsa_pkg::*;

  logic [ORDER_W-1:0] best_order;
  logic               take;

  // Keep the matching entry with the oldest add order
  assign take = ctl.sample && match && (!found || (order < best_order));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx   <= idx;
      best_gen   <= gen;
      best_order <= order;
    end
  end

endmodule

[sv/generational_graph_slot_allocator_core.sv]
// Adds, checks, edge removals and rejected items finish without a scan of the edge table.
// Node removal: one scan of the edge table per released edge, then one empty scan for each
//   direction (source, then target).
// One item at a time: the next beat is taken the cycle after the result is loaded.
// Reset (rst, synchronous): a clearing pass over max(NODE_SLOTS, EDGE_SLOTS) addresses sets
//   all generations to 1 and all slots free; req_ready stays low until it ends.
module generational_graph_slot_allocator_core #(
  parameter int NODE_SLOTS = 256,
  parameter int EDGE_SLOTS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ggsa_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ggsa_pkg::rsp_t  rsp
);
  import ggsa_pkg::*;
  `include "generational_graph_slot_allocator_core_macros.svh"

  localparam int NW    = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int EW    = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int MAXS  = (NODE_SLOTS > EDGE_SLOTS) ? NODE_SLOTS : EDGE_SLOTS;
  localparam int CW    = $clog2(MAXS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_NCHK  = 4'd3;
  localparam logic [3:0] S_ES    = 4'd4;
  localparam logic [3:0] S_ET    = 4'd5;
  localparam logic [3:0] S_POPW  = 4'd6;
  localparam logic [3:0] S_GENW  = 4'd7;
  localparam logic [3:0] S_ECHK  = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_SCEND = 4'd10;
  localparam logic [3:0] S_NREL  = 4'd11;
  localparam logic [3:0] S_RESP  = 4'd12;

  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
  } nent_t;

  typedef struct packed {
    logic               live;
    logic [GEN_W-1:0]   gen;
    logic [NW-1:0]      src;
    logic [NW-1:0]      tgt;
    logic [ORDER_W-1:0] order;
  } eent_t;

  // Memories
  nent_t         n_mem [NODE_SLOTS];
  eent_t         e_mem [EDGE_SLOTS];
  logic [NW-1:0] ns_mem [NODE_SLOTS];
  logic [EW-1:0] es_mem [EDGE_SLOTS];

  logic [NW-1:0] n_addr, ns_addr, ns_rdata, ns_wdata;
  logic [EW-1:0] e_addr, es_addr, es_rdata, es_wdata;
  nent_t         n_rdata, n_wdata;
  eent_t         e_rdata, e_wdata;
  logic          n_we, e_we, ns_we, es_we;

  always_ff @(posedge clk) begin
    if (n_we) begin
      n_mem[n_addr] <= n_wdata;
    end
    n_rdata <= n_mem[n_addr];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      e_mem[e_addr] <= e_wdata;
    end
    e_rdata <= e_mem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (ns_we) begin
      ns_mem[ns_addr] <= ns_wdata;
    end
    ns_rdata <= ns_mem[ns_addr];
  end

  always_ff @(posedge clk) begin
    if (es_we) begin
      es_mem[es_addr] <= es_wdata;
    end
    es_rdata <= es_mem[es_addr];
  end

  // Sequencer registers
  logic [3:0]         state, state_next;
  req_t               rq, rq_next;
  logic [2:0]         stat, stat_next;
  logic [9:0]         gidx, gidx_next;
  logic [GEN_W-1:0]   ggen, ggen_next;
  logic [GEN_W-1:0]   ngen, ngen_next;
  logic [CW-1:0]      clr_cnt, clr_cnt_next;
  logic [NW:0]        nfd, nfd_next, nfresh, nfresh_next;
  logic [EW:0]        efd, efd_next, efresh, efresh_next;
  logic [NW-1:0]      n_slot, n_slot_next;
  logic [EW-1:0]      e_slot, e_slot_next;
  logic [ORDER_W-1:0] order_cnt, order_cnt_next;
  logic [EW:0]        scan_cnt, scan_cnt_next;
  logic               scan_dv, scan_dv_next;
  logic [EW-1:0]      scan_didx, scan_didx_next;
  logic               phase, phase_next;
  logic               rsp_load;

  trk_ctl_t           trk_ctl;
  logic               trk_match, trk_found;
  logic [EW-1:0]      trk_idx;
  logic [GEN_W-1:0]   trk_gen;

  logic               src_ok, tgt_ok;

  assign req_ready = (state == S_IDLE);
  assign trk_match = e_rdata.live && (phase ? (e_rdata.src == NW'(rq.handle_index))
                                            : (e_rdata.tgt == NW'(rq.handle_index)));
  assign src_ok = (rq.source_generation != '0) && (32'(rq.source_index) < NODE_SLOTS)
                  && n_rdata.live && (n_rdata.gen == rq.source_generation);
  assign tgt_ok = (rq.target_generation != '0) && (32'(rq.target_index) < NODE_SLOTS)
                  && n_rdata.live && (n_rdata.gen == rq.target_generation);

  ggsa_min_track #(.EW(EW)) u_track (
    .clk      (clk),
    .rst      (rst),
    .ctl      (trk_ctl),
    .match    (trk_match),
    .idx      (scan_didx),
    .order    (e_rdata.order),
    .gen      (e_rdata.gen),
    .found    (trk_found),
    .best_idx (trk_idx),
    .best_gen (trk_gen)
  );

  // Next state and memory port control
  always_comb begin
    state_next     = state;
    rq_next        = rq;
    stat_next      = stat;
    gidx_next      = gidx;
    ggen_next      = ggen;
    ngen_next      = ngen;
    clr_cnt_next   = clr_cnt;
    nfd_next       = nfd;
    nfresh_next    = nfresh;
    efd_next       = efd;
    efresh_next    = efresh;
    n_slot_next    = n_slot;
    e_slot_next    = e_slot;
    order_cnt_next = order_cnt;
    scan_cnt_next  = scan_cnt;
    scan_dv_next   = 1'b0;
    scan_didx_next = scan_didx;
    phase_next     = phase;
    rsp_load       = 1'b0;
    trk_ctl        = '0;
    n_addr  = '0; n_we  = 1'b0; n_wdata  = '0;
    e_addr  = '0; e_we  = 1'b0; e_wdata  = '0;
    ns_addr = '0; ns_we = 1'b0; ns_wdata = '0;
    es_addr = '0; es_we = 1'b0; es_wdata = '0;

    case (state)
      // Sweep both tables to free, generation one
      S_CLR: begin
        n_addr       = NW'(clr_cnt);
        e_addr       = EW'(clr_cnt);
        n_wdata.gen  = GEN_W'(1);
        e_wdata.gen  = GEN_W'(1);
        n_we         = (32'(clr_cnt) < NODE_SLOTS);
        e_we         = (32'(clr_cnt) < EDGE_SLOTS);
        clr_cnt_next = clr_cnt + 1'b1;
        if (32'(clr_cnt) == MAXS - 1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          rq_next    = req;
          stat_next  = ST_OK;
          gidx_next  = '0;
          ggen_next  = '0;
          state_next = S_DISP;
        end
      end

      S_DISP: begin
        state_next = S_RESP;
        case (rq.func)
          F_ADD_NODE: begin
            if (nfd != '0) begin
              ns_addr    = NW'(nfd - 1'b1);
              nfd_next   = nfd - 1'b1;
              state_next = S_POPW;
            end else if (32'(nfresh) < NODE_SLOTS) begin
              n_slot_next = NW'(nfresh);
              n_addr      = NW'(nfresh);
              nfresh_next = nfresh + 1'b1;
              state_next  = S_GENW;
            end else begin
              stat_next = ST_FULL;
            end
          end
          F_RM_NODE, F_CHK_NODE: begin
            if (rq.handle_generation == '0) begin
              stat_next = ST_INVALID;
            end else if (32'(rq.handle_index) >= NODE_SLOTS) begin
              stat_next = ST_STALE;
            end else begin
              n_addr     = NW'(rq.handle_index);
              state_next = S_NCHK;
            end
          end
          F_ADD_EDGE: begin
            n_addr     = NW'(rq.source_index);
            state_next = S_ES;
          end
          F_RM_EDGE, F_CHK_EDGE: begin
            if (rq.handle_generation == '0) begin
              stat_next = ST_INVALID;
            end else if (32'(rq.handle_index) >= EDGE_SLOTS) begin
              stat_next = ST_STALE;
            end else begin
              e_addr     = EW'(rq.handle_index);
              state_next = S_ECHK;
            end
          end
          default: begin
            stat_next = ST_INVALID;
          end
        endcase
      end

      // Source endpoint read back; fetch the target
      S_ES: begin
        n_addr = NW'(rq.target_index);
        if (src_ok) begin
          state_next = S_ET;
        end else begin
          stat_next  = ST_ENDPOINT;
          state_next = S_RESP;
        end
      end

      // Target endpoint read back; pick an edge slot
      S_ET: begin
        state_next = S_RESP;
        if (!tgt_ok) begin
          stat_next = ST_ENDPOINT;
        end else if (efd != '0) begin
          es_addr    = EW'(efd - 1'b1);
          efd_next   = efd - 1'b1;
          state_next = S_POPW;
        end else if (32'(efresh) < EDGE_SLOTS) begin
          e_slot_next = EW'(efresh);
          e_addr      = EW'(efresh);
          efresh_next = efresh + 1'b1;
          state_next  = S_GENW;
        end else begin
          stat_next = ST_FULL;
        end
      end

      // Popped slot is available; fetch its entry
      S_POPW: begin
        if (rq.func == F_ADD_EDGE) begin
          e_slot_next = es_rdata;
          e_addr      = es_rdata;
        end else begin
          n_slot_next = ns_rdata;
          n_addr      = ns_rdata;
        end
        state_next = S_GENW;
      end

      // Mark the slot live and grant its generation
      S_GENW: begin
        if (rq.func == F_ADD_EDGE) begin
          e_addr         = e_slot;
          e_we           = 1'b1;
          e_wdata.live   = 1'b1;
          e_wdata.gen    = e_rdata.gen;
          e_wdata.src    = NW'(rq.source_index);
          e_wdata.tgt    = NW'(rq.target_index);
          e_wdata.order  = order_cnt;
          order_cnt_next = order_cnt + 1'b1;
          gidx_next      = 10'(e_slot);
          ggen_next      = e_rdata.gen;
        end else begin
          n_addr       = n_slot;
          n_we         = 1'b1;
          n_wdata.live = 1'b1;
          n_wdata.gen  = n_rdata.gen;
          gidx_next    = 10'(n_slot);
          ggen_next    = n_rdata.gen;
        end
        state_next = S_RESP;
      end

      S_NCHK: begin
        state_next = S_RESP;
        if (!n_rdata.live || (n_rdata.gen != rq.handle_generation)) begin
          stat_next = ST_STALE;
        end else if (rq.func == F_RM_NODE) begin
          ngen_next     = n_rdata.gen;
          phase_next    = 1'b1;
          scan_cnt_next = '0;
          trk_ctl.clear = 1'b1;
          state_next    = S_SCAN;
        end
      end

      S_ECHK: begin
        state_next = S_RESP;
        if (!e_rdata.live || (e_rdata.gen != rq.handle_generation)) begin
          stat_next = ST_STALE;
        end else if (rq.func == F_RM_EDGE) begin
          e_addr      = EW'(rq.handle_index);
          e_we        = 1'b1;
          e_wdata.gen = bump_gen(e_rdata.gen);
          es_addr     = EW'(efd);
          es_wdata    = EW'(rq.handle_index);
          if (32'(efd) < EDGE_SLOTS) begin
            es_we    = 1'b1;
            efd_next = efd + 1'b1;
          end
        end
      end

      // Stream the edge table through the tracker
      S_SCAN: begin
        trk_ctl.sample = scan_dv;
        if (32'(scan_cnt) < EDGE_SLOTS) begin
          e_addr         = EW'(scan_cnt);
          scan_dv_next   = 1'b1;
          scan_didx_next = EW'(scan_cnt);
          scan_cnt_next  = scan_cnt + 1'b1;
        end else if (!scan_dv) begin
          state_next = S_SCEND;
        end
      end

      // Release the oldest match, else move to the next direction or release the node
      S_SCEND: begin
        scan_cnt_next = '0;
        trk_ctl.clear = 1'b1;
        state_next    = S_SCAN;
        if (trk_found) begin
          e_addr      = trk_idx;
          e_we        = 1'b1;
          e_wdata.gen = bump_gen(trk_gen);
          es_addr     = EW'(efd);
          es_wdata    = trk_idx;
          if (32'(efd) < EDGE_SLOTS) begin
            es_we    = 1'b1;
            efd_next = efd + 1'b1;
          end
        end else if (phase) begin
          phase_next = 1'b0;
        end else begin
          state_next = S_NREL;
        end
      end

      S_NREL: begin
        n_addr      = NW'(rq.handle_index);
        n_we        = 1'b1;
        n_wdata.gen = bump_gen(ngen);
        ns_addr     = NW'(nfd);
        ns_wdata    = NW'(rq.handle_index);
        if (32'(nfd) < NODE_SLOTS) begin
          ns_we    = 1'b1;
          nfd_next = nfd + 1'b1;
        end
        state_next = S_RESP;
      end

      // Hand the result to the output register
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      nfd       <= '0;
      nfresh    <= '0;
      efd       <= '0;
      efresh    <= '0;
      order_cnt <= '0;
      scan_dv   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      nfd       <= nfd_next;
      nfresh    <= nfresh_next;
      efd       <= efd_next;
      efresh    <= efresh_next;
      order_cnt <= order_cnt_next;
      scan_dv   <= scan_dv_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rq        <= rq_next;
    stat      <= stat_next;
    gidx      <= gidx_next;
    ggen      <= ggen_next;
    ngen      <= ngen_next;
    n_slot    <= n_slot_next;
    e_slot    <= e_slot_next;
    scan_cnt  <= scan_cnt_next;
    scan_didx <= scan_didx_next;
    phase     <= phase_next;
    if (rsp_load) begin
      rsp.status             <= stat;
      rsp.granted_index      <= gidx;
      rsp.granted_generation <= ggen;
    end
  end

  `GGSA_ASSERT(a_node_free_le_used, nfd <= nfresh, "node free stack deeper than used slots")
  `GGSA_ASSERT(a_edge_free_le_used, efd <= efresh, "edge free stack deeper than used slots")
  `GGSA_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state == S_DISP,
                    "accepted item did not start")
  `GGSA_ASSERT_NEXT(a_load_valid, rsp_load, rsp_valid, "loaded result not presented")

endmodule

[sim/generational_graph_slot_allocator_core_tb.sv]
`timescale 1ns / 100ps

module generational_graph_slot_allocator_core_tb;
  import ggsa_pkg::*;

  localparam int NODE_CNT = 256;
  localparam int EDGE_CNT = 1024;
  localparam int RANDOM_ITEMS = 400;
  localparam int EDGE_CAP = 60;
  localparam int STALL_LIMIT = 400000;
  // Function codes the block does not define
  localparam logic [2:0] F_SPARE_A = 3'd6;
  localparam logic [2:0] F_SPARE_B = 3'd7;

  // Slot map mirror and response checker
  class slot_map_scoreboard;
    bit          node_live[NODE_CNT];
    bit [31:0]   node_gen[NODE_CNT];
    bit [7:0]    node_stack[NODE_CNT];
    int          node_depth;
    int          node_fresh;
    bit          edge_live[EDGE_CNT];
    bit [31:0]   edge_gen[EDGE_CNT];
    bit [7:0]    edge_src[EDGE_CNT];
    bit [7:0]    edge_tgt[EDGE_CNT];
    bit [47:0]   edge_order[EDGE_CNT];
    bit [9:0]    edge_stack[EDGE_CNT];
    int          edge_depth;
    int          edge_fresh;
    bit [47:0]   order_ctr;
    int          live_edges;
    rsp_t        expected_q[$];
    int          mismatches;

    function new();
      for (int i = 0; i < NODE_CNT; i++) node_gen[i] = 1;
      for (int i = 0; i < EDGE_CNT; i++) edge_gen[i] = 1;
    endfunction

    function bit [31:0] next_gen(bit [31:0] g);
      bit [31:0] n;
      n = g + 32'd1;
      return (n == 0) ? 32'd1 : n;
    endfunction

    function bit node_ok(int idx, bit [31:0] g);
      return g != 0 && idx < NODE_CNT && node_live[idx] && node_gen[idx] == g;
    endfunction

    function void free_edge(int e);
      edge_live[e] = 0;
      edge_gen[e] = next_gen(edge_gen[e]);
      live_edges--;
      if (edge_depth < EDGE_CNT) begin
        edge_stack[edge_depth] = 10'(e);
        edge_depth++;
      end
    endfunction

    // Free the edges touching node n on one side, oldest first
    function void free_edges_of(int n, bit by_src);
      int picks[$];
      int tmp;
      for (int e = 0; e < EDGE_CNT; e++)
        if (edge_live[e] && (by_src ? edge_src[e] : edge_tgt[e]) == n) picks = {picks, e};
      for (int i = 1; i < picks.size(); i++)
        for (int j = i; j > 0 && edge_order[picks[j-1]] > edge_order[picks[j]]; j--) begin
          tmp = picks[j]; picks[j] = picks[j-1]; picks[j-1] = tmp;
        end
      foreach (picks[k]) free_edge(picks[k]);
    endfunction

    // Apply one accepted request and queue its response
    function void note_request(req_t r);
      rsp_t x;
      int slot;
      x = '0;
      x.status = ST_OK;
      case (r.func)
        F_ADD_NODE: begin
          slot = -1;
          if (node_depth > 0) begin
            node_depth--;
            slot = int'(node_stack[node_depth]);
          end else if (node_fresh < NODE_CNT) begin
            slot = node_fresh;
            node_fresh++;
          end else x.status = ST_FULL;
          if (slot >= 0) begin
            node_live[slot] = 1;
            x.granted_index = 10'(slot);
            x.granted_generation = node_gen[slot];
          end
        end
        F_RM_NODE, F_CHK_NODE: begin
          if (r.handle_generation == 0) x.status = ST_INVALID;
          else if (!node_ok(int'(r.handle_index), r.handle_generation)) x.status = ST_STALE;
          else if (r.func == F_RM_NODE) begin
            free_edges_of(int'(r.handle_index), 1'b1);
            free_edges_of(int'(r.handle_index), 1'b0);
            node_live[r.handle_index] = 0;
            node_gen[r.handle_index] = next_gen(node_gen[r.handle_index]);
            if (node_depth < NODE_CNT) begin
              node_stack[node_depth] = 8'(r.handle_index);
              node_depth++;
            end
          end
        end
        F_ADD_EDGE: begin
          slot = -1;
          if (!node_ok(int'(r.source_index), r.source_generation) ||
              !node_ok(int'(r.target_index), r.target_generation)) x.status = ST_ENDPOINT;
          else if (edge_depth > 0) begin
            edge_depth--;
            slot = int'(edge_stack[edge_depth]);
          end else if (edge_fresh < EDGE_CNT) begin
            slot = edge_fresh;
            edge_fresh++;
          end else x.status = ST_FULL;
          if (slot >= 0) begin
            edge_live[slot] = 1;
            live_edges++;
            edge_src[slot] = r.source_index;
            edge_tgt[slot] = r.target_index;
            edge_order[slot] = order_ctr;
            order_ctr++;
            x.granted_index = 10'(slot);
            x.granted_generation = edge_gen[slot];
          end
        end
        F_RM_EDGE, F_CHK_EDGE: begin
          if (r.handle_generation == 0) x.status = ST_INVALID;
          else if (!edge_live[r.handle_index] || edge_gen[r.handle_index] != r.handle_generation)
            x.status = ST_STALE;
          else if (r.func == F_RM_EDGE) free_edge(int'(r.handle_index));
        end
        default: x.status = ST_INVALID;
      endcase
      expected_q = {expected_q, x};
    endfunction

    // Compare one response beat against the oldest expectation
    function void check_response(rsp_t a);
      rsp_t x;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", a);
        return;
      end
      x = expected_q.pop_front();
      if (a.status !== x.status || a.granted_index !== x.granted_index ||
          a.granted_generation !== x.granted_generation) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp status %0d idx %0d gen %0d, got status %0d idx %0d gen %0d",
                   x.status, x.granted_index, x.granted_generation,
                   a.status, a.granted_index, a.granted_generation);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;

  slot_map_scoreboard sb = new();
  int burst_left = 0;
  int hold_cnt = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int stall_phase = 0;
  int idle_cycles = 0;

  generational_graph_slot_allocator_core u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Check every response beat
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // Stall the response side: one long hold on request, else a rotating pattern
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_ready <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_cnt <= 400;
      rsp_ready <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      rsp_ready <= stall_phase[6] ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("generational_graph_slot_allocator_core_tb: FAIL");
      $finish;
    end
  end

  function automatic req_t mk(logic [2:0] f, int hidx, logic [31:0] hgen,
                              int sidx = 0, logic [31:0] sgen = 0,
                              int tidx = 0, logic [31:0] tgen = 0);
    req_t r;
    r.func = f;
    r.handle_index = 10'(hidx);
    r.handle_generation = hgen;
    r.source_index = 8'(sidx);
    r.source_generation = sgen;
    r.target_index = 8'(tidx);
    r.target_generation = tgen;
    return r;
  endfunction

  function automatic req_t noise();
    req_t r;
    r = mk(3'($urandom_range(0, 7)), int'($urandom_range(0, 1023)), $urandom(),
           int'($urandom_range(0, 255)), $urandom(), int'($urandom_range(0, 255)), $urandom());
    if ($urandom_range(0, 3) == 0) r.handle_generation = 0;
    return r;
  endfunction

  function automatic int pick_node();
    int idx;
    for (int t = 0; t < 32; t++) begin
      idx = int'($urandom_range(0, NODE_CNT - 1));
      if (sb.node_live[idx]) return idx;
    end
    for (int i = 0; i < NODE_CNT; i++) if (sb.node_live[i]) return i;
    return -1;
  endfunction

  function automatic int pick_edge();
    int idx;
    idx = int'($urandom_range(0, EDGE_CNT - 1));
    for (int i = 0; i < EDGE_CNT; i++)
      if (sb.edge_live[(idx + i) % EDGE_CNT]) return (idx + i) % EDGE_CNT;
    return -1;
  endfunction

  // Drive one request beat, with bursts separated by random gaps
  task automatic send(input req_t r);
    if (burst_left == 0) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(20, 40))
                                                : int'($urandom_range(1, 8));
    end
    req <= r;
    req_valid <= 1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
    burst_left--;
  endtask

  task automatic add_random_edge();
    int s, t;
    s = pick_node();
    t = ($urandom_range(0, 7) == 0) ? s : pick_node();
    if (s < 0) send(mk(F_ADD_NODE, 0, 0));
    else send(mk(F_ADD_EDGE, int'($urandom_range(0, 1023)), $urandom(),
                 s, sb.node_gen[s], t, sb.node_gen[t]));
  endtask

  task automatic random_item();
    int k, n, e;
    k = int'($urandom_range(0, 99));
    n = pick_node();
    e = pick_edge();
    if (k < 10) send(noise());
    else if (k < 25 || n < 0)
      send(mk(F_ADD_NODE, int'($urandom_range(0, 1023)), $urandom()));
    else if (k < 33) send(mk(F_RM_NODE, n, sb.node_gen[n]));
    else if (k < 40) send(mk(F_CHK_NODE, n, sb.node_gen[n]));
    else if (k < 45) send(mk($urandom_range(0, 1) ? F_CHK_NODE : F_RM_NODE,
                             n, sb.node_gen[n] - $urandom_range(1, 3)));
    else if (k < 65 && sb.live_edges < EDGE_CAP) add_random_edge();
    else if (k < 70) begin
      // broken endpoint: stale source generation
      send(mk(F_ADD_EDGE, 0, 0, n, sb.node_gen[n] + 32'd1, n, sb.node_gen[n]));
    end else if (e < 0) add_random_edge();
    else if (k < 85) send(mk(F_RM_EDGE, e, sb.edge_gen[e]));
    else if (k < 94) send(mk(F_CHK_EDGE, e, sb.edge_gen[e]));
    else send(mk($urandom_range(0, 1) ? F_CHK_EDGE : F_RM_EDGE, e, sb.edge_gen[e] + 32'd1));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: basic adds, checks, endpoint and handle errors, self-loop, node removal
    send(mk(F_ADD_NODE, 0, 0));
    send(mk(F_ADD_NODE, 1023, 32'hFFFF_FFFF, 255, 32'hFFFF_FFFF, 255, 32'hFFFF_FFFF));
    send(mk(F_ADD_NODE, 0, 0));
    send(mk(F_CHK_NODE, 0, 1));
    send(mk(F_CHK_NODE, 0, 0));
    send(mk(F_CHK_NODE, 300, 1));
    send(mk(F_CHK_NODE, 1, 2));
    send(mk(F_ADD_EDGE, 0, 0, 0, 1, 1, 1));
    send(mk(F_ADD_EDGE, 0, 0, 1, 1, 1, 1));
    send(mk(F_ADD_EDGE, 0, 0, 1, 1, 0, 1));
    send(mk(F_ADD_EDGE, 0, 0, 0, 0, 1, 1));
    send(mk(F_ADD_EDGE, 0, 0, 0, 1, 200, 1));
    send(mk(F_CHK_EDGE, 0, 1));
    send(mk(F_RM_EDGE, 0, 1));
    send(mk(F_RM_EDGE, 0, 1));
    send(mk(F_RM_EDGE, 5, 0));
    send(mk(F_CHK_EDGE, 1023, 1));
    send(mk(F_RM_NODE, 1, 1));
    send(mk(F_CHK_NODE, 1, 1));
    send(mk(F_CHK_EDGE, 1, 1));
    send(mk(F_RM_NODE, 0, 0));
    send(mk(F_SPARE_A, 0, 1));
    send(mk(F_SPARE_B, 1023, 32'hFFFF_FFFF));
    send(mk(F_ADD_NODE, 0, 0));

    // Fill the node table, then one add past full
    while (sb.node_depth > 0 || sb.node_fresh < NODE_CNT) send(mk(F_ADD_NODE, 0, 0));
    send(mk(F_ADD_NODE, 0, 0));

    // Pause until everything has drained
    req_valid <= 0;
    wait (sb.expected_q.size() == 0);
    @(posedge clk);

    // Random phase, with one long receiver hold early on
    hold_req = 1;
    for (int i = 0; i < RANDOM_ITEMS; i++) random_item();
    req_valid <= 0;

    wait (sb.expected_q.size() == 0);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("generational_graph_slot_allocator_core_tb: PASS");
    else
      $display("generational_graph_slot_allocator_core_tb: FAIL");
    $finish;
  end

endmodule
